FILE: design/jit3_pkg.sv
// Shared types and constants for the 3D Jacobian inverse-transpose unit.
package jit3_pkg;

  // One accepted node, as passed from the front end to the back end
  typedef struct packed {
    logic signed [31:0] node_x;
    logic signed [31:0] node_y;
    logic signed [31:0] node_z;
    logic signed [31:0] dphi_xi;
    logic signed [31:0] dphi_eta;
    logic signed [31:0] dphi_zeta;
    logic signed [31:0] quad_weight;
    logic               last_node;
  } jit3_node_t;

  localparam int NodeBits = $bits(jit3_node_t);

  // One finished result
  typedef struct packed {
    logic signed [31:0] inv_00;
    logic signed [31:0] inv_01;
    logic signed [31:0] inv_02;
    logic signed [31:0] inv_10;
    logic signed [31:0] inv_11;
    logic signed [31:0] inv_12;
    logic signed [31:0] inv_20;
    logic signed [31:0] inv_21;
    logic signed [31:0] inv_22;
    logic signed [31:0] determinant;
    logic signed [31:0] weighted_det;
    logic               singular;
  } jit3_res_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_ENTRY,
    ST_COF,
    ST_DET,
    ST_WDET,
    ST_DIV,
    ST_OUT
  } jit3_state_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) r = 32'sh7fffffff;
    else if (v < -68'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

FILE: design/jit3_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module jit3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

FILE: design/jit3_front.sv
// Front end: node intake and a short queue towards the back end.
module jit3_front
  import jit3_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  jit3_node_t in_node,
  output logic       q_valid,
  input  logic       q_ready,
  output jit3_node_t q_node
);

  localparam int Depth = 4;
  localparam int AW = $clog2(Depth);

  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;
  logic          push, pop;
  logic [NodeBits-1:0] rdata;
  logic          rvalid;

  // read data registered in the RAM; one entry prefetched into an output slot
  assign in_ready = (count != (AW+1)'(Depth));
  assign push = in_valid && in_ready;
  assign pop  = (count != '0) && (!rvalid || q_ready);

  jit3_ram #(.WIDTH(NodeBits), .DEPTH(Depth)) u_ram (
    .clk(clk), .we(push), .waddr(wptr), .wdata(in_node),
    .re(pop), .raddr(rptr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
      rvalid <= 1'b0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
      if (pop) rvalid <= 1'b1;
      else if (q_ready) rvalid <= 1'b0;
    end
  end

  assign q_valid = rvalid;
  assign q_node  = rdata;

endmodule

FILE: design/jit3_back.sv
// Back end: Jacobian accumulation, cofactors, determinant and division sequencer.
module jit3_back
  import jit3_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  output logic       q_ready,
  input  jit3_node_t q_node,
  output logic       res_valid,
  input  logic       res_ready,
  output jit3_res_t  res
);

  jit3_state_t state, state_next;
  jit3_node_t  node;
  logic signed [63:0] sums [9];
  logic signed [31:0] m [9];
  logic signed [31:0] cf [9];
  logic signed [31:0] det, wdet;
  logic signed [31:0] inv [9];
  logic [3:0] idx;
  // shared multiplier, one product a cycle
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod, prod_r;
  logic [1:0] phase;
  logic signed [63:0] acc_a;
  logic signed [65:0] dsum;
  // divider
  logic [5:0]  dbit;
  logic [31+FRAC_BITS:0] dnum, dquo;
  logic [32:0] drem;
  logic [31:0] dden;
  logic        dneg;
  logic [32:0] trial;
  logic [32+FRAC_BITS:0] qmag;
  logic        rv;
  jit3_res_t   rres;

  // cofactor operand selection: {p,q,r,s} indexes per cofactor
  function automatic logic [15:0] cof_ops(input logic [3:0] k);
    logic [15:0] r;
    case (k)
      4'd0: r = {4'd4, 4'd8, 4'd5, 4'd7};
      4'd1: r = {4'd5, 4'd6, 4'd3, 4'd8};
      4'd2: r = {4'd3, 4'd7, 4'd4, 4'd6};
      4'd3: r = {4'd2, 4'd7, 4'd1, 4'd8};
      4'd4: r = {4'd0, 4'd8, 4'd2, 4'd6};
      4'd5: r = {4'd1, 4'd6, 4'd0, 4'd7};
      4'd6: r = {4'd1, 4'd5, 4'd2, 4'd4};
      4'd7: r = {4'd2, 4'd3, 4'd0, 4'd5};
      default: r = {4'd0, 4'd4, 4'd1, 4'd3};
    endcase
    return r;
  endfunction

  // row and column of MAC step k, row-major over the nine sums
  function automatic logic [3:0] mac_rc(input logic [3:0] k);
    logic [3:0] r;
    case (k)
      4'd0: r = {2'd0, 2'd0};
      4'd1: r = {2'd0, 2'd1};
      4'd2: r = {2'd0, 2'd2};
      4'd3: r = {2'd1, 2'd0};
      4'd4: r = {2'd1, 2'd1};
      4'd5: r = {2'd1, 2'd2};
      4'd6: r = {2'd2, 2'd0};
      4'd7: r = {2'd2, 2'd1};
      default: r = {2'd2, 2'd2};
    endcase
    return r;
  endfunction

  function automatic logic signed [63:0] fsh(input logic signed [63:0] v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] crd(input jit3_node_t n, input logic [1:0] r);
    logic signed [31:0] v;
    case (r)
      2'd0: v = n.node_x;
      2'd1: v = n.node_y;
      default: v = n.node_z;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] dph(input jit3_node_t n, input logic [1:0] c);
    logic signed [31:0] v;
    case (c)
      2'd0: v = n.dphi_xi;
      2'd1: v = n.dphi_eta;
      default: v = n.dphi_zeta;
    endcase
    return v;
  endfunction

  logic [15:0] ops;
  logic [3:0]  rc;
  logic [3:0]  idx_m1;
  logic signed [64:0] sadd;
  logic [3:0]  sidx;

  assign ops = cof_ops(idx);
  assign rc = mac_rc(idx);
  assign idx_m1 = idx - 4'd1;

  // multiplier operand select by state and step
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_MAC: begin
        ma = crd(node, rc[3:2]);
        mb = dph(node, rc[1:0]);
      end
      ST_COF: begin
        ma = phase[0] ? m[ops[7:4]]  : m[ops[15:12]];
        mb = phase[0] ? m[ops[3:0]]  : m[ops[11:8]];
      end
      ST_DET: begin
        ma = m[idx[1:0] == 2'd0 ? 4'd0 : (idx[1:0] == 2'd1 ? 4'd3 : 4'd6)];
        mb = cf[idx[1:0] == 2'd0 ? 4'd0 : (idx[1:0] == 2'd1 ? 4'd3 : 4'd6)];
      end
      ST_WDET: begin
        ma = det;
        mb = node.quad_weight;
      end
      default: ;
    endcase
  end
  assign prod = ma * mb;

  // accumulation add of the registered product, saturating at 64 bits
  assign sidx = idx_m1;
  assign sadd = {sums[sidx[3:0]][63], sums[sidx[3:0]]} + {prod_r[63], prod_r};

  assign dsum = 66'(acc_a) + 66'(fsh(prod_r));
  assign trial = {drem[31:0], dnum[31+FRAC_BITS]} - {1'b0, dden};
  assign qmag = {1'b0, dquo[30+FRAC_BITS:0], !trial[32]};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (q_valid) state_next = ST_MAC;
      ST_MAC:   if (idx == 4'd9)
                  state_next = node.last_node ? ST_ENTRY : ST_IDLE;
      ST_ENTRY: state_next = ST_COF;
      ST_COF:   if (idx == 4'd9) state_next = ST_DET;
      ST_DET:   if (idx == 4'd3 && phase == 2'd1) state_next = ST_WDET;
      ST_WDET:  if (phase == 2'd1) state_next = ST_DIV;
      ST_DIV:   if (idx == 4'd9) state_next = ST_OUT;
      ST_OUT:   if (!rv) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign q_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx <= '0;
      phase <= '0;
      rv <= 1'b0;
      for (int k = 0; k < 9; k++) sums[k] <= '0;
    end else begin
      state <= state_next;
      prod_r <= prod;
      if (rv && res_ready) rv <= 1'b0;
      case (state)
        ST_IDLE: begin
          idx <= '0;
          if (q_valid) node <= q_node;
        end
        ST_MAC: begin
          // product of step idx-1 is in prod_r
          if (idx != 4'd0) begin
            if (sadd > 65'sh0_7fff_ffff_ffff_ffff) sums[sidx] <= 64'sh7fff_ffff_ffff_ffff;
            else if (sadd < -65'sh0_8000_0000_0000_0000)
              sums[sidx] <= 64'sh8000_0000_0000_0000;
            else sums[sidx] <= sadd[63:0];
          end
          idx <= (idx == 4'd9) ? 4'd0 : idx + 4'd1;
        end
        ST_ENTRY: begin
          for (int k = 0; k < 9; k++) begin
            m[k] <= sat32(68'(fsh(sums[k])));
            sums[k] <= '0;
          end
          idx <= '0;
          phase <= '0;
        end
        ST_COF: begin
          // phase 0: p*q issued, 1: r*s issued and p*q taken, 2: r*s taken
          if (idx == 4'd9) begin
            idx <= '0;
            phase <= '0;
            acc_a <= '0;
          end else begin
            phase <= phase + 2'd1;
            if (phase == 2'd1) acc_a <= fsh(prod_r);
            if (phase == 2'd2) cf[idx] <= sat32(68'(acc_a) - 68'(fsh(prod_r)));
            if (phase == 2'd3) idx <= idx + 4'd1;
          end
        end
        ST_DET: begin
          // phase 0 issue, phase 1 accumulate
          phase <= phase ^ 2'd1;
          if (phase == 2'd1) begin
            acc_a <= dsum[63:0];
            if (idx == 4'd2) det <= sat32(68'(dsum));
            idx <= idx + 4'd1;
          end
        end
        ST_WDET: begin
          phase <= phase ^ 2'd1;
          if (phase == 2'd1) begin
            wdet <= sat32(68'(fsh(prod_r)));
            idx <= '0;
            dbit <= '0;
          end
        end
        ST_DIV: begin
          // restoring division, one quotient bit a cycle
          if (dbit == 6'd0) begin
            dnum <= (cf[idx][31] ? 32'(-cf[idx]) : 32'(cf[idx])) << FRAC_BITS;
            dden <= det[31] ? 32'(-det) : 32'(det);
            dneg <= cf[idx][31] ^ det[31];
            drem <= '0;
            dquo <= '0;
            dbit <= 6'd1;
          end else begin
            if (!trial[32]) drem <= trial;
            else drem <= {drem[31:0], dnum[31+FRAC_BITS]};
            dnum <= dnum << 1;
            dquo <= {dquo[30+FRAC_BITS:0], !trial[32]};
            if (dbit == 6'(32 + FRAC_BITS)) begin
              dbit <= '0;
              if (det == '0) inv[idx] <= '0;
              else inv[idx] <= sat32(dneg ? -68'(qmag) : 68'(qmag));
              idx <= idx + 4'd1;
            end else dbit <= dbit + 6'd1;
          end
        end
        ST_OUT: begin
          if (!rv) begin
            rv <= 1'b1;
            rres.inv_00 <= inv[0]; rres.inv_01 <= inv[1]; rres.inv_02 <= inv[2];
            rres.inv_10 <= inv[3]; rres.inv_11 <= inv[4]; rres.inv_12 <= inv[5];
            rres.inv_20 <= inv[6]; rres.inv_21 <= inv[7]; rres.inv_22 <= inv[8];
            rres.determinant <= det;
            rres.weighted_det <= (det == '0) ? '0 : wdet;
            rres.singular <= (det == '0);
          end
        end
        default: ;
      endcase
    end
  end

  assign res_valid = rv;
  assign res = rres;

endmodule

FILE: design/jacobian_inverse_transpose_3d_unit.sv
// Top level of the 3D Jacobian inverse-transpose unit.
// In the back end each node takes nine MACs on one shared multiplier.
// A last node then adds entry, cofactor, determinant and weight work,
// bit-serial division of the nine entries and the load of the result.
// A four-entry node queue lets input transfers continue while the back end works.
// Reset (rst, synchronous) empties the queue, clears the sums and the result valid.
module jacobian_inverse_transpose_3d_unit
  import jit3_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // node_x, node_y, node_z, dphi_xi, dphi_eta, dphi_zeta, quad_weight
  input  logic [223:0] s_tdata,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // inv_00..inv_22, determinant, weighted_det
  output logic [351:0] m_tdata,
  // singular
  output logic         m_tuser
);

  jit3_node_t in_node, q_node;
  jit3_res_t  res;
  logic       q_valid, q_ready;

  assign in_node.node_x      = s_tdata[31:0];
  assign in_node.node_y      = s_tdata[63:32];
  assign in_node.node_z      = s_tdata[95:64];
  assign in_node.dphi_xi     = s_tdata[127:96];
  assign in_node.dphi_eta    = s_tdata[159:128];
  assign in_node.dphi_zeta   = s_tdata[191:160];
  assign in_node.quad_weight = s_tdata[223:192];
  assign in_node.last_node   = s_tlast;

  jit3_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready), .in_node(in_node),
    .q_valid(q_valid), .q_ready(q_ready), .q_node(q_node)
  );

  jit3_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_node(q_node),
    .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
  );

  assign m_tdata = {res.weighted_det, res.determinant, res.inv_22, res.inv_21, res.inv_20,
                    res.inv_12, res.inv_11, res.inv_10, res.inv_02, res.inv_01, res.inv_00};
  assign m_tuser = res.singular;

  // a singular result carries zero entries
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[319:0] == '0)
    else $error("singular result with non-zero entries");

  // a pending result holds while stalled
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

endmodule

FILE: tb/sv/jacobian_inverse_transpose_3d_unit_test.sv
// Self-checking testbench for the 3D Jacobian inverse-transpose unit.
`timescale 1ns / 100ps

module jacobian_inverse_transpose_3d_unit_test;
  import jit3_pkg::*;

  localparam int FRAC = 16;
  localparam longint S64_MAX = 64'sh7fffffffffffffff;
  localparam longint S64_MIN = 64'sh8000000000000000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [223:0] s_tdata;
  logic         s_tlast;
  logic         m_tvalid;
  logic         m_tready;
  logic [351:0] m_tdata;
  logic         m_tuser;

  jacobian_inverse_transpose_3d_unit #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // Transfer queues and scoreboard
  jit3_node_t node_q[$];
  jit3_res_t  result_q[$];
  longint     jac_acc[9];
  int         mismatches = 0;
  int         results_seen = 0;
  int         singular_seen = 0;
  int         nodes_sent = 0;
  bit         stim_done = 0;
  bit         hold_sender = 0;
  bit         long_stall = 0;

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Predictor helpers
  function automatic longint sat_to32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint floor_frac(longint v);
    return v >>> FRAC;
  endfunction

  function automatic longint add_sat64(longint a, longint b);
    if (b > 0 && a > S64_MAX - b) return S64_MAX;
    if (b < 0 && a < S64_MIN - b) return S64_MIN;
    return a + b;
  endfunction

  function automatic longint cofactor(longint p, longint q, longint r, longint s);
    return sat_to32(floor_frac(p * q) - floor_frac(r * s));
  endfunction

  // Accumulate one node; on the last node push the expected result
  task automatic predict_node(input jit3_node_t n);
    longint crd[3], dph[3], m[9], cf[9], det, wdet, v;
    jit3_res_t res;
    crd[0] = longint'(n.node_x);  crd[1] = longint'(n.node_y);
    crd[2] = longint'(n.node_z);
    dph[0] = longint'(n.dphi_xi); dph[1] = longint'(n.dphi_eta);
    dph[2] = longint'(n.dphi_zeta);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        jac_acc[r*3+c] = add_sat64(jac_acc[r*3+c], crd[r] * dph[c]);
    if (!n.last_node) return;
    for (int i = 0; i < 9; i++) begin
      m[i] = sat_to32(floor_frac(jac_acc[i]));
      jac_acc[i] = 0;
    end
    cf[0] = cofactor(m[4], m[8], m[5], m[7]);
    cf[1] = cofactor(m[5], m[6], m[3], m[8]);
    cf[2] = cofactor(m[3], m[7], m[4], m[6]);
    cf[3] = cofactor(m[2], m[7], m[1], m[8]);
    cf[4] = cofactor(m[0], m[8], m[2], m[6]);
    cf[5] = cofactor(m[1], m[6], m[0], m[7]);
    cf[6] = cofactor(m[1], m[5], m[2], m[4]);
    cf[7] = cofactor(m[2], m[3], m[0], m[5]);
    cf[8] = cofactor(m[0], m[4], m[1], m[3]);
    det = sat_to32(floor_frac(m[0]*cf[0]) + floor_frac(m[3]*cf[3]) +
                   floor_frac(m[6]*cf[6]));
    wdet = sat_to32(floor_frac(det * longint'(n.quad_weight)));
    res = '0;
    for (int i = 0; i < 9; i++) begin
      v = (det != 0) ? sat_to32((cf[i] <<< FRAC) / det) : 0;
      case (i)
        0: res.inv_00 = v[31:0];
        1: res.inv_01 = v[31:0];
        2: res.inv_02 = v[31:0];
        3: res.inv_10 = v[31:0];
        4: res.inv_11 = v[31:0];
        5: res.inv_12 = v[31:0];
        6: res.inv_20 = v[31:0];
        7: res.inv_21 = v[31:0];
        default: res.inv_22 = v[31:0];
      endcase
    end
    res.determinant  = det[31:0];
    res.weighted_det = wdet[31:0];
    res.singular     = (det == 0);
    result_q.push_back(res);
  endtask

  // Driver: bursts and gaps, drawn from the pending node queue
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_node(node_q.pop_front());
        nodes_sent++;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left > 0) gap_left--;
        if (node_q.size() > 0 && !hold_sender && gap_left == 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {node_q[0].quad_weight, node_q[0].dphi_zeta, node_q[0].dphi_eta,
                       node_q[0].dphi_xi, node_q[0].node_z, node_q[0].node_y,
                       node_q[0].node_x};
          s_tlast  <= node_q[0].last_node;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, plus one long hold-off counted here
  int stall_phase = 0;
  int long_count = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (long_stall) begin
      long_count++;
      m_tready <= 1'b0;
      if (long_count >= 3000) begin
        long_stall = 0;
        long_count = 0;
      end
    end else begin
      stall_phase = (stall_phase + 1) % 64;
      if (stall_phase < 20) m_tready <= 1'b1;
      else m_tready <= ($urandom_range(0, 2) != 0);
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    jit3_res_t got, exp_res;
    if (!rst && m_tvalid && m_tready) begin
      got = '0;
      {got.weighted_det, got.determinant, got.inv_22, got.inv_21, got.inv_20,
       got.inv_12, got.inv_11, got.inv_10, got.inv_02, got.inv_01,
       got.inv_00} = m_tdata;
      got.singular = m_tuser;
      results_seen++;
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result transfer");
      end else begin
        exp_res = result_q.pop_front();
        if (got.singular) singular_seen++;
        if (got !== exp_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d\n  exp %h\n  got %h", results_seen,
                     exp_res, got);
        end
      end
    end
  end

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 262143) - 131072;  // about -2.0 .. 2.0
      3: return $urandom_range(0, 8388607) - 4194304;
      default: return $urandom();
    endcase
  endfunction

  function automatic jit3_node_t make_node(logic signed [31:0] x, y, z, dx, dy, dz, w,
                                           logic last);
    jit3_node_t n;
    n.node_x = x; n.node_y = y; n.node_z = z;
    n.dphi_xi = dx; n.dphi_eta = dy; n.dphi_zeta = dz;
    n.quad_weight = w; n.last_node = last;
    return n;
  endfunction

  // Point of the given node count: corners as coordinates and small derivatives, or random words if wild
  task automatic queue_point(int nodes, bit wild);
    jit3_node_t n;
    for (int k = 0; k < nodes; k++) begin
      if (wild)
        n = make_node(rand_word(), rand_word(), rand_word(), rand_word(),
                      rand_word(), rand_word(), rand_word(), k == nodes - 1);
      else
        n = make_node($urandom_range(0, 1048575) - 524288,
                      $urandom_range(0, 1048575) - 524288,
                      $urandom_range(0, 1048575) - 524288,
                      $urandom_range(0, 65535) - 32768,
                      $urandom_range(0, 65535) - 32768,
                      $urandom_range(0, 65535) - 32768,
                      $urandom_range(0, 131072), k == nodes - 1);
      node_q.push_back(n);
    end
  endtask

  localparam logic signed [31:0] ONE = 32'sh00010000;
  localparam logic signed [31:0] MAXV = 32'sh7fffffff;
  localparam logic signed [31:0] MINV = 32'sh80000000;

  // Stimulus
  initial begin
    int total;
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0; m_tready = 1'b0;
    for (int i = 0; i < 9; i++) jac_acc[i] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Identity from three unit nodes, weight one
    node_q.push_back(make_node(ONE, 0, 0, ONE, 0, 0, ONE, 0));
    node_q.push_back(make_node(0, ONE, 0, 0, ONE, 0, ONE, 0));
    node_q.push_back(make_node(0, 0, ONE, 0, 0, ONE, ONE, 1));
    // Singular: single node, rank one, and all-zero
    node_q.push_back(make_node(ONE, ONE, ONE, ONE, ONE, ONE, ONE, 1));
    node_q.push_back(make_node(0, 0, 0, 0, 0, 0, MAXV, 1));
    // Accumulator saturation, both signs
    node_q.push_back(make_node(MAXV, MINV, MAXV, MAXV, MINV, MINV, MINV, 0));
    node_q.push_back(make_node(MAXV, MINV, MAXV, MAXV, MINV, MINV, MINV, 0));
    node_q.push_back(make_node(MAXV, MINV, MAXV, MAXV, MINV, MINV, MINV, 1));
    node_q.push_back(make_node(MINV, MINV, MINV, MINV, MINV, MINV, MINV, 1));
    // Tiny diagonal: determinant underflows to zero
    node_q.push_back(make_node(1, 0, 0, 1, 0, 0, ONE, 0));
    node_q.push_back(make_node(0, 1, 0, 0, 1, 0, ONE, 0));
    node_q.push_back(make_node(0, 0, 1, 0, 0, 1, ONE, 1));
    // Large scaled diagonal, negative weight, extreme weight
    node_q.push_back(make_node(32'sh01000000, 0, 0, 32'sh01000000, 0, 0, -ONE, 0));
    node_q.push_back(make_node(0, -ONE, 0, 0, ONE, 0, MAXV, 0));
    node_q.push_back(make_node(0, 0, 32'sh00008000, 0, 0, ONE, MAXV, 1));
    queue_point(4, 0);
    queue_point(8, 1);

    // Random points, mostly well-formed points of one to eight nodes, some noise
    while (nodes_sent + node_q.size() + 8 < 550) begin
      if ($urandom_range(0, 4) == 0) queue_point($urandom_range(1, 3), 1);
      else queue_point($urandom_range(0, 3) == 0 ? 8 : $urandom_range(1, 8), 0);
      // Long receiver hold-off while nodes keep coming
      if (node_q.size() > 250 && node_q.size() < 260) begin
        wait (node_q.size() < 200);
        long_stall = 1;
      end
    end
    total = node_q.size();

    // Sender pause until all results are in
    wait (node_q.size() < total / 2);
    hold_sender = 1;
    wait (node_q.size() == 0 || (result_q.size() == 0 && !s_tvalid));
    wait (result_q.size() == 0);
    repeat (4) @(posedge clk);
    hold_sender = 0;

    wait (node_q.size() == 0);
    @(posedge clk);
    wait (result_q.size() == 0 && !s_tvalid);
    repeat (1200) @(posedge clk);
    stim_done = 1;
  end

  // Final verdict
  initial begin
    wait (stim_done);
    $display("Sent %0d nodes, checked %0d results (%0d singular), %0d mismatches.",
             nodes_sent, results_seen, singular_seen, mismatches);
    if (mismatches == 0 && result_q.size() == 0)
      $display("jacobian_inverse_transpose_3d_unit_test OK");
    else
      $display("jacobian_inverse_transpose_3d_unit_test NOT OK");
    $finish;
  end

  // Watchdog
  initial begin
    #400ms;
    $display("Timeout: %0d results still expected", result_q.size());
    $display("jacobian_inverse_transpose_3d_unit_test NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
design/jit3_pkg.sv
design/jit3_ram.sv
design/jit3_front.sv
design/jit3_back.sv
design/jacobian_inverse_transpose_3d_unit.sv
tb/sv/jacobian_inverse_transpose_3d_unit_test.sv
